### design/bmp_rgb24_stream_decoder_macros.svh
// Assertion helpers for the BMP stream decoder checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BMP_RGB24_STREAM_DECODER_MACROS_SVH
`define BMP_RGB24_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRGB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/brgb_pkg.sv
package brgb_pkg;

  // Image limits and result dimension width.
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned DimW      = 13;

  // Depth of the command queue between parser and result stage.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Byte positions of the header fields.
  localparam logic [31:0] PosSig     = 32'd0;
  localparam logic [31:0] PosOffset  = 32'd10;
  localparam logic [31:0] PosHdrSize = 32'd14;
  localparam logic [31:0] PosWidth   = 32'd18;
  localparam logic [31:0] PosHeight  = 32'd22;
  localparam logic [31:0] PosDepth   = 32'd28;
  localparam logic [31:0] PosComp    = 32'd30;
  localparam logic [31:0] PosCheck   = 32'd33;
  localparam logic [31:0] PosPixel   = PosCheck + 32'd1;

  // Expected header contents.
  localparam logic [31:0] InfoHdrSize = 32'd40;
  localparam logic [15:0] PixelDepth  = 16'd24;
  localparam logic [31:0] MinOffset   = 32'd54;
  localparam logic [7:0]  SigB        = 8'h42;
  localparam logic [7:0]  SigM        = 8'h4D;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    ST_PIXEL      = 4'd0,
    ST_SIGNATURE  = 4'd1,
    ST_HDR_SIZE   = 4'd2,
    ST_COMPRESSED = 4'd3,
    ST_DEPTH      = 4'd4,
    ST_OFFSET     = 4'd5,
    ST_TOO_LARGE  = 4'd6,
    ST_EMPTY      = 4'd7,
    ST_TRUNCATED  = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    status_e         status;
    logic            last;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } res_t;

  // One queue entry: a result, optionally followed by a truncation result.
  typedef struct packed {
    res_t res;
    logic trunc;
  } cmd_t;

endpackage

### design/bmp_rgb24_stream_decoder.sv
// A result passes through the command queue and then the output register before it is offered.
// Throughput: one byte per cycle while the queue has room, one result per cycle while not stalled.
// A final byte that completes a pixel before the image is done yields two results.
// The four-entry queue between parser and result register sets how long output stalls are absorbed.
// Reset (asynchronous, active low) returns the parser to the header and empties queue and output.
module bmp_rgb24_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [3:0]  status_o,
  output logic        last_o,
  output logic [12:0] image_width_o,
  output logic [12:0] image_height_o
);
  import brgb_pkg::*;

  // The parser only stalls when the queue has no room for another command.
  // Output stalls therefore reach the input only after the queue fills.
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_cmd;
  cmd_t q_head;
  res_t res;

  assign in_stall_o = q_full;

  // The front parses the header, skips to the pixel data, assembles BGR triples
  // and drops row padding; every transaction that produces output pushes one command.
  brgb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .stall_i       (q_full),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .end_of_file_i (end_of_file_i),
    .push_o        (q_push),
    .cmd_o         (q_cmd)
  );

  brgb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // The back holds the output register and expands a command carrying a
  // pending truncation into the pixel result followed by the status result.
  brgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign red_o          = res.red;
  assign green_o        = res.green;
  assign blue_o         = res.blue;
  assign status_o       = res.status;
  assign last_o         = res.last;
  assign image_width_o  = res.width;
  assign image_height_o = res.height;

endmodule

### design/brgb_front.sv
module brgb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          stall_i,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          end_of_file_i,
  output logic          push_o,
  output brgb_pkg::cmd_t cmd_o
);
  import brgb_pkg::*;

  logic [31:0] pos_q, pos_d;
  logic [15:0] sig_q, sig_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] hsize_q, hsize_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [15:0] depth_q, depth_d;
  logic [31:0] comp_q, comp_d;
  phase_e      phase_q, phase_d;
  logic [15:0] held_q, held_d;
  logic [1:0]  bip_q, bip_d;
  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic [1:0]  pad_q, pad_d;

  logic    accept;
  logic    stop;
  logic    pix;
  logic    fin;
  status_e st;
  cmd_t    cmd;

  function automatic logic [31:0] put32(input logic [31:0] field, input logic [31:0] pos,
                                        input logic [31:0] start, input logic [7:0] b);
    logic [31:0] rel;
    logic [31:0] res;
    rel = pos - start;
    res = field;
    if (rel < 32'd4) begin
      res[{rel[1:0], 3'b000} +: 8] = b;
    end
    return res;
  endfunction

  function automatic logic [15:0] put16(input logic [15:0] field, input logic [31:0] pos,
                                        input logic [31:0] start, input logic [7:0] b);
    logic [31:0] rel;
    logic [15:0] res;
    rel = pos - start;
    res = field;
    if (rel < 32'd2) begin
      res[{rel[0], 3'b000} +: 8] = b;
    end
    return res;
  endfunction

  function automatic status_e check_hdr(input logic [15:0] sig, input logic [31:0] hsize,
                                        input logic [31:0] comp, input logic [15:0] depth,
                                        input logic [31:0] offset, input logic [31:0] w,
                                        input logic [31:0] h);
    status_e res;
    res = ST_PIXEL;
    if (sig[7:0] != SigB || sig[15:8] != SigM) begin
      res = ST_SIGNATURE;
    end else if (hsize != InfoHdrSize) begin
      res = ST_HDR_SIZE;
    end else if (comp != 32'd0) begin
      res = ST_COMPRESSED;
    end else if (depth != PixelDepth) begin
      res = ST_DEPTH;
    end else if (offset < MinOffset) begin
      res = ST_OFFSET;
    end else if (w > 32'(MaxWidth) || h > 32'(MaxHeight)) begin
      res = ST_TOO_LARGE;
    end else if (w == 32'd0 || h == 32'd0) begin
      res = ST_EMPTY;
    end
    return res;
  endfunction

  assign accept = in_valid_i && !stall_i;

  always_comb begin
    pos_d    = pos_q;
    sig_d    = sig_q;
    offset_d = offset_q;
    hsize_d  = hsize_q;
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    comp_d   = comp_q;
    phase_d  = phase_q;
    held_d   = held_q;
    bip_d    = bip_q;
    col_d    = col_q;
    row_d    = row_q;
    pad_d    = pad_q;
    stop     = 1'b0;
    pix      = 1'b0;
    fin      = 1'b0;
    st       = ST_PIXEL;
    push_o   = 1'b0;
    cmd      = '0;

    if (accept) begin
      if (first_byte_i) begin
        pos_d    = '0;
        sig_d    = '0;
        offset_d = '0;
        hsize_d  = '0;
        width_d  = '0;
        height_d = '0;
        depth_d  = '0;
        comp_d   = '0;
        phase_d  = PH_HEADER;
        held_d   = '0;
        bip_d    = '0;
        col_d    = '0;
        row_d    = '0;
        pad_d    = '0;
      end

      unique case (phase_d)
        PH_HEADER: begin
          sig_d    = put16(sig_d, pos_d, PosSig, data_byte_i);
          offset_d = put32(offset_d, pos_d, PosOffset, data_byte_i);
          hsize_d  = put32(hsize_d, pos_d, PosHdrSize, data_byte_i);
          width_d  = put32(width_d, pos_d, PosWidth, data_byte_i);
          height_d = put32(height_d, pos_d, PosHeight, data_byte_i);
          depth_d  = put16(depth_d, pos_d, PosDepth, data_byte_i);
          comp_d   = put32(comp_d, pos_d, PosComp, data_byte_i);
          if (pos_d == PosCheck) begin
            st = check_hdr(sig_d, hsize_d, comp_d, depth_d, offset_d, width_d, height_d);
            if (st != ST_PIXEL) begin
              stop           = 1'b1;
              push_o         = 1'b1;
              cmd.res.status = st;
              cmd.res.last   = 1'b1;
              phase_d        = PH_DONE;
            end else begin
              phase_d = (offset_d == PosPixel) ? PH_PIXEL : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (pos_d == offset_d - 32'd1) begin
            phase_d = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          unique case (bip_d)
            2'd0: begin
              held_d = {8'd0, data_byte_i};
              bip_d  = 2'd1;
            end
            2'd1: begin
              held_d[15:8] = data_byte_i;
              bip_d        = 2'd2;
            end
            default: begin
              bip_d = 2'd0;
              col_d = col_d + 1'b1;
              if (32'(col_d) >= width_d) begin
                col_d = '0;
                row_d = row_d + 1'b1;
                if (32'(row_d) >= height_d) begin
                  fin = 1'b1;
                end else if (width_d[1:0] != 2'd0) begin
                  pad_d   = width_d[1:0];
                  phase_d = PH_PAD;
                end
              end
              pix             = 1'b1;
              push_o          = 1'b1;
              cmd.res.red     = data_byte_i;
              cmd.res.green   = held_d[15:8];
              cmd.res.blue    = held_d[7:0];
              cmd.res.status  = ST_PIXEL;
              cmd.res.last    = fin;
              if (fin) begin
                stop    = 1'b1;
                phase_d = PH_DONE;
              end
            end
          endcase
        end
        PH_PAD: begin
          pad_d = pad_d - 2'd1;
          if (pad_d == 2'd0) begin
            phase_d = PH_PIXEL;
          end
        end
        PH_DONE: begin
          stop = 1'b1;
        end
        default: begin
          stop = 1'b1;
        end
      endcase

      if (!stop) begin
        if (pos_d != '1) begin
          pos_d = pos_d + 32'd1;
        end
        if (end_of_file_i) begin
          phase_d = PH_DONE;
          push_o  = 1'b1;
          if (pix) begin
            cmd.trunc = 1'b1;
          end else begin
            cmd.res.status = ST_TRUNCATED;
            cmd.res.last   = 1'b1;
          end
        end
      end

      cmd.res.width  = (width_d > 32'(MaxWidth)) ? DimW'(MaxWidth) : width_d[DimW-1:0];
      cmd.res.height = (height_d > 32'(MaxHeight)) ? DimW'(MaxHeight) : height_d[DimW-1:0];
    end
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sig_q    <= '0;
      offset_q <= '0;
      hsize_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      comp_q   <= '0;
      phase_q  <= PH_HEADER;
      held_q   <= '0;
      bip_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      pad_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      sig_q    <= sig_d;
      offset_q <= offset_d;
      hsize_q  <= hsize_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      comp_q   <= comp_d;
      phase_q  <= phase_d;
      held_q   <= held_d;
      bip_q    <= bip_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pad_q    <= pad_d;
    end
  end

endmodule

### design/brgb_queue.sv
module brgb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  brgb_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output brgb_pkg::cmd_t head_o
);
  import brgb_pkg::*;

  cmd_t           mem_q [QDepth];
  logic [QAw-1:0] wr_q, wr_d;
  logic [QAw-1:0] rd_q, rd_d;
  logic [QAw:0]   count_q, count_d;

  assign full_o  = (count_q == (QAw + 1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d    = push_i ? wr_q + 1'b1 : wr_q;
    rd_d    = pop_i ? rd_q + 1'b1 : rd_q;
    count_d = count_q + (QAw + 1)'(push_i) - (QAw + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

### design/brgb_back.sv
module brgb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  brgb_pkg::cmd_t head_i,
  output logic           pop_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output brgb_pkg::res_t res_o
);
  import brgb_pkg::*;

  logic valid_q, valid_d;
  logic pend_q, pend_d;
  res_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    res_d   = res_q;
    pop_o   = 1'b0;
    if (!valid_q || !out_stall_i) begin
      if (pend_q) begin
        // The pixel finished by the final byte has gone; the truncation follows it.
        res_d.red    = '0;
        res_d.green  = '0;
        res_d.blue   = '0;
        res_d.status = ST_TRUNCATED;
        res_d.last   = 1'b1;
        pend_d       = 1'b0;
        valid_d      = 1'b1;
      end else if (!empty_i) begin
        pop_o   = 1'b1;
        res_d   = head_i.res;
        pend_d  = head_i.trunc;
        valid_d = 1'b1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### design/brgb_checker.sv
`include "bmp_rgb24_stream_decoder_macros.svh"

module brgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [7:0]  red_i,
  input logic [7:0]  green_i,
  input logic [7:0]  blue_i,
  input logic [3:0]  status_i,
  input logic        last_i,
  input logic [12:0] image_width_i,
  input logic [12:0] image_height_i
);
  import brgb_pkg::*;

  // A stalled result stays offered and unchanged.
  `BRGB_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i) && $stable(status_i) && $stable(last_i) && $stable(image_width_i) && $stable(image_height_i), "stalled result changed")

  // Every status result closes the file.
  `BRGB_ASSERT_IMPL(a_fault_last, out_valid_i && status_i != ST_PIXEL, last_i, "status result without last")

  // Status results carry no color.
  `BRGB_ASSERT_IMPL(a_fault_dark, out_valid_i && status_i != ST_PIXEL, red_i == 8'd0 && green_i == 8'd0 && blue_i == 8'd0, "status result with color")

  // Reported dimensions are saturated at the limits.
  `BRGB_ASSERT_IMPL(a_dims_sat, out_valid_i, image_width_i <= DimW'(MaxWidth) && image_height_i <= DimW'(MaxHeight), "dimension above limit")

endmodule

bind bmp_rgb24_stream_decoder brgb_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .red_i          (red_o),
  .green_i        (green_o),
  .blue_i         (blue_o),
  .status_i       (status_o),
  .last_i         (last_o),
  .image_width_i  (image_width_o),
  .image_height_i (image_height_o)
);

### dv/tb.sv
`timescale 1ns / 1ps

// Stream-level test of the 24-bit BMP decoder.
//
// A queue of file bytes is built up front: a directed list of files that hit
// each header fault, every way a file can end early, padding widths, restarts
// and saturated dimensions, followed by random files that are mostly
// well-formed with random pixel data, plus broken headers and raw noise.
// The driver pops that queue onto the input channel and, for every accepted
// transaction, runs a local model of the parser that queues the results the
// block must produce. The monitor pops one expected result for every output
// transaction and compares all fields.
module tb;
  import brgb_pkg::*;

  // Generous cycle bound; a correct run needs a small fraction of it.
  localparam int unsigned CycleLimit = 400000;
  // Rough size of the random part, in file bytes.
  localparam int unsigned RandomBytes = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       eof;
  } file_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        first_byte_i = 1'b0;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [3:0]  status_o;
  logic        last_o;
  logic [12:0] image_width_o;
  logic [12:0] image_height_o;

  bmp_rgb24_stream_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

  // Pending file bytes, and the decoded results still owed by the block.
  file_byte_t file_bytes_q[$];
  res_t       decoded_q[$];
  file_byte_t next_byte;

  int unsigned total_bytes = 0;
  int unsigned accepted = 0;
  int unsigned fails = 0;
  int unsigned cycles = 0;

  // Parser model state. Header fields are kept at their full 32-bit width so
  // that oversized dimensions are caught exactly as the block must catch them.
  logic [31:0] byte_idx;
  logic [15:0] sig_word;
  logic [31:0] pix_off;
  logic [31:0] hdr_len;
  logic [31:0] wid_fld;
  logic [31:0] hgt_fld;
  logic [15:0] bpp_fld;
  logic [31:0] comp_fld;
  phase_e      stage;
  logic [15:0] held;
  logic [1:0]  pix_byte;
  logic [12:0] col;
  logic [12:0] row;
  logic [1:0]  pad_cnt;

  task automatic clear_decoder();
    byte_idx = '0;
    sig_word = '0;
    pix_off  = '0;
    hdr_len  = '0;
    wid_fld  = '0;
    hgt_fld  = '0;
    bpp_fld  = '0;
    comp_fld = '0;
    stage    = PH_HEADER;
    held     = '0;
    pix_byte = '0;
    col      = '0;
    row      = '0;
    pad_cnt  = '0;
  endtask

  // Every result carries the dimensions captured so far, clipped to the limits.
  task automatic expect_result(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input status_e st,
                               input logic lst);
    res_t res;
    res.red    = r;
    res.green  = g;
    res.blue   = b;
    res.status = st;
    res.last   = lst;
    res.width  = (wid_fld > MaxWidth) ? DimW'(MaxWidth) : wid_fld[DimW-1:0];
    res.height = (hgt_fld > MaxHeight) ? DimW'(MaxHeight) : hgt_fld[DimW-1:0];
    decoded_q.push_back(res);
  endtask

  // Advances the parser model by one file byte and queues what it produces.
  task automatic decode_byte(input logic [7:0] b, input logic first, input logic eof);
    status_e st;
    logic    fin;
    logic    halt;
    halt = 1'b0;
    fin  = 1'b0;
    if (first) clear_decoder();
    case (stage)
      PH_HEADER: begin
        if (byte_idx <= 32'd1)
          sig_word = sig_word | (16'(b) << (byte_idx * 8));
        else if (byte_idx >= 32'd10 && byte_idx <= 32'd13)
          pix_off = pix_off | (32'(b) << ((byte_idx - 32'd10) * 8));
        else if (byte_idx >= 32'd14 && byte_idx <= 32'd17)
          hdr_len = hdr_len | (32'(b) << ((byte_idx - 32'd14) * 8));
        else if (byte_idx >= 32'd18 && byte_idx <= 32'd21)
          wid_fld = wid_fld | (32'(b) << ((byte_idx - 32'd18) * 8));
        else if (byte_idx >= 32'd22 && byte_idx <= 32'd25)
          hgt_fld = hgt_fld | (32'(b) << ((byte_idx - 32'd22) * 8));
        else if (byte_idx >= 32'd28 && byte_idx <= 32'd29)
          bpp_fld = bpp_fld | (16'(b) << ((byte_idx - 32'd28) * 8));
        else if (byte_idx >= 32'd30 && byte_idx <= 32'd33)
          comp_fld = comp_fld | (32'(b) << ((byte_idx - 32'd30) * 8));
        if (byte_idx == 32'd33) begin
          // The checks run in a fixed order; only the first failing one reports.
          if (sig_word != {SigM, SigB}) st = ST_SIGNATURE;
          else if (hdr_len != InfoHdrSize) st = ST_HDR_SIZE;
          else if (comp_fld != '0) st = ST_COMPRESSED;
          else if (bpp_fld != PixelDepth) st = ST_DEPTH;
          else if (pix_off < MinOffset) st = ST_OFFSET;
          else if (wid_fld > MaxWidth || hgt_fld > MaxHeight) st = ST_TOO_LARGE;
          else if (wid_fld == '0 || hgt_fld == '0) st = ST_EMPTY;
          else st = ST_PIXEL;
          if (st != ST_PIXEL) begin
            // A header fault is the file's only result, even with end of file.
            expect_result(8'h00, 8'h00, 8'h00, st, 1'b1);
            stage = PH_DONE;
            halt  = 1'b1;
          end else begin
            stage = (pix_off == 32'd34) ? PH_PIXEL : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (byte_idx == pix_off - 32'd1) stage = PH_PIXEL;
      end
      PH_PIXEL: begin
        // Bytes arrive blue, green, red; the third one completes the pixel.
        if (pix_byte == 2'd0) begin
          held     = {8'h00, b};
          pix_byte = 2'd1;
        end else if (pix_byte == 2'd1) begin
          held[15:8] = b;
          pix_byte   = 2'd2;
        end else begin
          pix_byte = 2'd0;
          col      = col + 13'd1;
          if ({19'd0, col} >= wid_fld) begin
            col = '0;
            row = row + 13'd1;
            if ({19'd0, row} >= hgt_fld) begin
              fin = 1'b1;
            end else if (wid_fld[1:0] != 2'd0) begin
              pad_cnt = wid_fld[1:0];
              stage   = PH_PAD;
            end
          end
          expect_result(b, held[15:8], held[7:0], ST_PIXEL, fin);
          if (fin) begin
            // The final pixel closes the file; end of file adds nothing here.
            stage = PH_DONE;
            halt  = 1'b1;
          end
        end
      end
      PH_PAD: begin
        pad_cnt = pad_cnt - 2'd1;
        if (pad_cnt == 2'd0) stage = PH_PIXEL;
      end
      default: begin
        // Finished file: bytes are dropped until the next first byte.
        halt = 1'b1;
      end
    endcase
    if (!halt) begin
      if (byte_idx != '1) byte_idx = byte_idx + 32'd1;
      if (eof) begin
        expect_result(8'h00, 8'h00, 8'h00, ST_TRUNCATED, 1'b1);
        stage = PH_DONE;
      end
    end
  endtask

  // Queues the first len bytes of a file with the given header. Bytes past the
  // header, and header bytes that hold no checked field, are random.
  task automatic add_file(input logic [15:0] sig, input logic [31:0] hsz,
                          input logic [31:0] w, input logic [31:0] h,
                          input logic [15:0] bpp, input logic [31:0] comp,
                          input logic [31:0] off, input int unsigned len,
                          input bit mark_first, input bit mark_eof);
    logic [7:0] hdr [34];
    file_byte_t fb;
    for (int i = 0; i < 34; i++) hdr[i] = 8'($urandom);
    {hdr[1], hdr[0]} = sig;
    {hdr[13], hdr[12], hdr[11], hdr[10]} = off;
    {hdr[17], hdr[16], hdr[15], hdr[14]} = hsz;
    {hdr[21], hdr[20], hdr[19], hdr[18]} = w;
    {hdr[25], hdr[24], hdr[23], hdr[22]} = h;
    {hdr[29], hdr[28]} = bpp;
    {hdr[33], hdr[32], hdr[31], hdr[30]} = comp;
    for (int unsigned i = 0; i < len; i++) begin
      fb.data  = (i < 34) ? hdr[i] : 8'($urandom);
      fb.first = mark_first && (i == 0);
      fb.eof   = mark_eof && (i == len - 1);
      file_bytes_q.push_back(fb);
    end
  endtask

  task automatic good_file(input int unsigned w, input int unsigned h,
                           input int unsigned off, input int unsigned len,
                           input bit mark_first, input bit mark_eof);
    add_file({SigM, SigB}, InfoHdrSize, w, h, PixelDepth, '0, off, len,
             mark_first, mark_eof);
  endtask

  // Length up to and including the final pixel: every row but the last is padded.
  function automatic int unsigned image_len(input int unsigned w, input int unsigned h,
                                            input int unsigned off);
    return off + (w * 3 + w % 4) * (h - 1) + w * 3;
  endfunction

  // Idle percentages: sender light and receiver heavy, then swapped, then none.
  function automatic int unsigned idle_pct(input bit rx);
    int unsigned third;
    third = (total_bytes == 0) ? 0 : (accepted * 3) / total_bytes;
    if (third == 0) return rx ? 47 : 26;
    if (third == 1) return rx ? 26 : 47;
    return 0;
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Input driver: one transaction per handshake, payload held while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      clear_decoder();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(data_byte_i, first_byte_i, end_of_file_i);
        accepted <= accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (file_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          next_byte = file_bytes_q.pop_front();
          in_valid_i    <= 1'b1;
          data_byte_i   <= next_byte.data;
          first_byte_i  <= next_byte.first;
          end_of_file_i <= next_byte.eof;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each result transaction against the oldest
  // expectation and throttles the output with random stalls.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: rgb %02h %02h %02h status %0d last %0b dim %0d x %0d",
                     red_o, green_o, blue_o, status_o, last_o, image_width_o,
                     image_height_o);
        end else begin
          want = decoded_q.pop_front();
          if (want.red !== red_o || want.green !== green_o || want.blue !== blue_o ||
              want.status !== status_o || want.last !== last_o ||
              want.width !== image_width_o || want.height !== image_height_o) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected rgb %02h %02h %02h status %0d last %0b dim %0d x %0d",
                       want.red, want.green, want.blue, want.status, want.last,
                       want.width, want.height);
              $display("          actual   rgb %02h %02h %02h status %0d last %0b dim %0d x %0d",
                       red_o, green_o, blue_o, status_o, last_o, image_width_o,
                       image_height_o);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_pct(1'b1));
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned directed_len;
    int unsigned kind;
    int unsigned w;
    int unsigned h;
    int unsigned off;
    int unsigned full;
    logic [15:0] f_sig;
    logic [31:0] f_hsz;
    logic [31:0] f_w;
    logic [31:0] f_h;
    logic [15:0] f_bpp;
    logic [31:0] f_comp;
    logic [31:0] f_off;
    file_byte_t  fb;

    // The very first file carries no first-byte marker: after reset the
    // parser must treat the first byte it sees as byte zero.
    good_file(1, 1, 54, image_len(1, 1, 54), 0, 1);
    // Padding of three, none, and two bytes per row; end of file on the
    // byte that completes the image gives only the final pixel.
    good_file(3, 2, 54, image_len(3, 2, 54), 1, 1);
    good_file(4, 2, 55, image_len(4, 2, 55), 1, 1);
    good_file(2, 3, 54, image_len(2, 3, 54), 1, 1);
    // Trailing bytes after a complete image, end of file on an ignored byte.
    good_file(1, 1, 54, image_len(1, 1, 54) + 3, 1, 1);

    // Header faults, at least one per check. The first ends on byte 33 with end of
    // file, which must give the fault alone; two keep going to show that
    // later bytes are dropped.
    add_file({8'h58, SigB}, InfoHdrSize, 1, 1, PixelDepth, '0, 54, 34, 1, 1);
    add_file({SigM, 8'h41}, InfoHdrSize, 1, 1, PixelDepth, '0, 54, 40, 1, 0);
    add_file(16'h0000, InfoHdrSize, 1, 1, PixelDepth, '0, 54, 38, 1, 1);
    add_file({SigM, SigB}, 32'd12, 1, 1, PixelDepth, '0, 54, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, 1, 1, PixelDepth, 32'd1, 54, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, 1, 1, 16'd32, '0, 54, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, 1, 1, PixelDepth, '0, 34, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, 1, 1, PixelDepth, '0, 53, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, 4097, 1, PixelDepth, '0, 54, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, 1, '1, PixelDepth, '0, 54, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, '1, 4097, PixelDepth, '0, 54, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, 0, 1, PixelDepth, '0, 54, 34, 1, 0);
    add_file({SigM, SigB}, InfoHdrSize, 1, 0, PixelDepth, '0, 54, 34, 1, 0);

    // Early ends: on the first byte itself, inside the header, on a good
    // byte 33, in the skip area, mid-pixel, on a finished pixel (pixel then
    // truncation), and in row padding.
    good_file(2, 2, 54, 1, 1, 1);
    good_file(2, 2, 54, 11, 1, 1);
    good_file(2, 2, 54, 34, 1, 1);
    good_file(2, 2, 60, 58, 1, 1);
    good_file(2, 2, 54, 56, 1, 1);
    good_file(2, 2, 54, 57, 1, 1);
    good_file(1, 2, 54, 58, 1, 1);
    // Largest legal dimensions, cut short after ten pixels.
    good_file(MaxWidth, MaxHeight, 54, 84, 1, 1);
    // A file abandoned without end of file, restarted by the next first byte.
    good_file(5, 2, 56, 70, 1, 0);
    good_file(5, 2, 56, image_len(5, 2, 56), 1, 1);
    directed_len = file_bytes_q.size();

    // Random part: mostly well-formed files with random content and sizes,
    // the rest cut short, corrupted, or plain noise.
    while (file_bytes_q.size() - directed_len < RandomBytes) begin
      kind = $urandom_range(99);
      w    = ($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      h    = $urandom_range(1, 4);
      off  = 54 + $urandom_range(0, 8);
      full = image_len(w, h, off);
      if (kind < 60) begin
        good_file(w, h, off, full, 1, 1);
      end else if (kind < 68) begin
        good_file(w, h, off, full + $urandom_range(1, 4), 1, $urandom_range(1));
      end else if (kind < 76) begin
        good_file(w, h, off, $urandom_range(1, full - 1), 1, 1);
      end else if (kind < 80) begin
        good_file(w, h, off, $urandom_range(1, full - 1), 1, 0);
      end else if (kind < 90) begin
        f_sig  = {SigM, SigB};
        f_hsz  = InfoHdrSize;
        f_w    = w;
        f_h    = h;
        f_bpp  = PixelDepth;
        f_comp = '0;
        f_off  = off;
        case ($urandom_range(6))
          0: f_sig = $urandom_range(1) ? {8'($urandom), SigB} : 16'($urandom);
          1: f_hsz = $urandom;
          2: f_comp = $urandom_range(1) ? 32'd1 : 32'($urandom);
          3: f_bpp = 16'($urandom);
          4: f_off = $urandom_range(0, 53);
          5: begin
            if ($urandom_range(1)) f_w = $urandom_range(1) ? 32'd4097 : 32'($urandom);
            else f_h = $urandom_range(1) ? 32'd4097 : 32'($urandom);
          end
          default: begin
            if ($urandom_range(1)) f_w = '0;
            else f_h = '0;
          end
        endcase
        add_file(f_sig, f_hsz, f_w, f_h, f_bpp, f_comp, f_off,
                 34 + $urandom_range(0, 4), 1, $urandom_range(1));
      end else begin
        repeat ($urandom_range(1, 60)) begin
          fb.data  = 8'($urandom);
          fb.first = ($urandom_range(19) == 0);
          fb.eof   = ($urandom_range(29) == 0);
          file_bytes_q.push_back(fb);
        end
      end
    end
    total_bytes = file_bytes_q.size();

    // Drain: every byte accepted, every result seen, then a quiet wait
    // in which any stray result would be flagged.
    @(posedge rst_ni);
    while (file_bytes_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fails == 0 && decoded_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/brgb_pkg.sv
design/brgb_front.sv
design/brgb_queue.sv
design/brgb_back.sv
design/bmp_rgb24_stream_decoder.sv
design/brgb_checker.sv
dv/tb.sv
